FILE: rtl/modular_inverse_macros.svh
// Assertion macros shared by the checker
`ifndef MODULAR_INVERSE_MACROS_SVH
`define MODULAR_INVERSE_MACROS_SVH

// Consequent holds in the same cycle as the antecedent
`define MI_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("modular_inverse check failed");

// Consequent holds in the cycle after the antecedent
`define MI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("modular_inverse check failed");

`endif

FILE: rtl/modinv_pkg.sv
package modinv_pkg;

  localparam int WIDTH_DEF   = 32;
  localparam int FIELD_W     = 32;
  localparam int IN_TDATA_W  = 2 * FIELD_W;
  localparam int OUT_TDATA_W = FIELD_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_INIT,
    S_UP,
    S_DOWN,
    S_SWAP,
    S_TEST,
    S_DONE,
    S_FAIL
  } state_t;

  typedef struct packed {
    logic load;
    logic init;
    logic up;
    logic down;
    logic swap;
    logic swap_red;
    logic wr_ok;
    logic wr_fail;
  } cmd_t;

  typedef struct packed {
    logic mod_le1;
    logic r1_zero;
    logic up_more;
    logic k_zero;
    logic gcd_one;
    logic out_free;
  } stat_t;

endpackage

FILE: rtl/modinv_ctrl.sv
module modinv_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  modinv_pkg::stat_t  stat,
  output modinv_pkg::cmd_t   cmd
);

  modinv_pkg::state_t state_r, state_nxt;
  logic red_r, red_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= modinv_pkg::S_IDLE;
      red_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      red_r   <= red_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    red_nxt   = red_r;
    case (state_r)
      modinv_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = modinv_pkg::S_CHECK;
      end
      modinv_pkg::S_CHECK: begin
        if (stat.mod_le1) begin
          state_nxt = modinv_pkg::S_FAIL;
        end else begin
          state_nxt = modinv_pkg::S_INIT;
          red_nxt   = 1'b1;
        end
      end
      modinv_pkg::S_INIT: state_nxt = modinv_pkg::S_UP;
      modinv_pkg::S_UP: begin
        if (!stat.up_more) state_nxt = modinv_pkg::S_DOWN;
      end
      modinv_pkg::S_DOWN: begin
        if (stat.k_zero) state_nxt = modinv_pkg::S_SWAP;
      end
      modinv_pkg::S_SWAP: begin
        state_nxt = modinv_pkg::S_TEST;
        red_nxt   = 1'b0;
      end
      modinv_pkg::S_TEST: begin
        state_nxt = stat.r1_zero ? modinv_pkg::S_DONE : modinv_pkg::S_INIT;
      end
      modinv_pkg::S_DONE, modinv_pkg::S_FAIL: begin
        if (stat.out_free) state_nxt = modinv_pkg::S_IDLE;
      end
      default: state_nxt = modinv_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      modinv_pkg::S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      modinv_pkg::S_INIT: cmd.init = 1'b1;
      modinv_pkg::S_UP:   cmd.up   = stat.up_more;
      modinv_pkg::S_DOWN: cmd.down = 1'b1;
      modinv_pkg::S_SWAP: begin
        cmd.swap     = 1'b1;
        cmd.swap_red = red_r;
      end
      modinv_pkg::S_DONE: begin
        cmd.wr_ok   = stat.out_free & stat.gcd_one;
        cmd.wr_fail = stat.out_free & ~stat.gcd_one;
      end
      modinv_pkg::S_FAIL: cmd.wr_fail = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

FILE: rtl/modinv_dp.sv
module modinv_dp #(
  parameter int WIDTH = modinv_pkg::WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [modinv_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  modinv_pkg::cmd_t                   cmd,
  output modinv_pkg::stat_t                  stat,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [modinv_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                               out_tuser
);

  localparam int KW = $clog2(WIDTH);

  logic [WIDTH-1:0] r0_r, r0_nxt, r1_r, r1_nxt, mod_r, mod_nxt;
  logic [WIDTH-1:0] u0_r, u0_nxt, u1_r, u1_nxt;
  logic [WIDTH:0]   d_r, d_nxt, v_r, v_nxt;
  logic [KW-1:0]    k_r, k_nxt;
  logic             neg0_r, neg0_nxt, neg1_r, neg1_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [modinv_pkg::OUT_TDATA_W-1:0] out_inv_r, out_inv_nxt;
  logic             out_stat_r, out_stat_nxt;

  logic [WIDTH-1:0] a_in, m_in, inv_res;
  logic [WIDTH:0]   rem_ext, d_dbl, diff, sum;
  logic             fits;

  assign a_in    = WIDTH'(in_tdata[modinv_pkg::FIELD_W-1:0]);
  assign m_in    = WIDTH'(in_tdata[modinv_pkg::IN_TDATA_W-1:modinv_pkg::FIELD_W]);
  assign rem_ext = {1'b0, r0_r};
  assign d_dbl   = {d_r[WIDTH-1:0], 1'b0};
  assign fits    = (d_r <= rem_ext);
  assign diff    = rem_ext - d_r;
  assign sum     = {1'b0, u0_r} + v_r;
  assign inv_res = (neg0_r && (u0_r != '0)) ? (mod_r - u0_r) : u0_r;

  always_comb begin
    stat.mod_le1  = (mod_r <= WIDTH'(1));
    stat.r1_zero  = (r1_r == '0);
    stat.up_more  = (d_dbl <= rem_ext);
    stat.k_zero   = (k_r == '0);
    stat.gcd_one  = (r0_r == WIDTH'(1));
    stat.out_free = ~out_valid_r | out_tready;
  end

  always_comb begin
    r0_nxt   = r0_r;
    r1_nxt   = r1_r;
    mod_nxt  = mod_r;
    u0_nxt   = u0_r;
    u1_nxt   = u1_r;
    d_nxt    = d_r;
    v_nxt    = v_r;
    k_nxt    = k_r;
    neg0_nxt = neg0_r;
    neg1_nxt = neg1_r;
    if (cmd.load) begin
      r0_nxt  = a_in;
      r1_nxt  = m_in;
      mod_nxt = m_in;
      u0_nxt  = '0;
      u1_nxt  = '0;
    end
    if (cmd.init) begin
      d_nxt = {1'b0, r1_r};
      v_nxt = {1'b0, u1_r};
      k_nxt = '0;
    end
    if (cmd.up) begin
      d_nxt = d_dbl;
      v_nxt = {v_r[WIDTH-1:0], 1'b0};
      k_nxt = k_r + KW'(1);
    end
    if (cmd.down) begin
      if (fits) begin
        r0_nxt = diff[WIDTH-1:0];
        u0_nxt = sum[WIDTH-1:0];
      end
      d_nxt = {1'b0, d_r[WIDTH:1]};
      v_nxt = {1'b0, v_r[WIDTH:1]};
      k_nxt = k_r - KW'(1);
    end
    if (cmd.swap) begin
      r0_nxt = r1_r;
      r1_nxt = r0_r;
      if (cmd.swap_red) begin
        u0_nxt   = '0;
        u1_nxt   = WIDTH'(1);
        neg0_nxt = 1'b0;
        neg1_nxt = 1'b0;
      end else begin
        u0_nxt   = u1_r;
        u1_nxt   = u0_r;
        neg0_nxt = neg1_r;
        neg1_nxt = ~neg1_r;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r & ~out_tready;
    out_inv_nxt   = out_inv_r;
    out_stat_nxt  = out_stat_r;
    if (cmd.wr_ok) begin
      out_valid_nxt = 1'b1;
      out_inv_nxt   = modinv_pkg::OUT_TDATA_W'(inv_res);
      out_stat_nxt  = 1'b0;
    end else if (cmd.wr_fail) begin
      out_valid_nxt = 1'b1;
      out_inv_nxt   = '0;
      out_stat_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    r0_r      <= r0_nxt;
    r1_r      <= r1_nxt;
    mod_r     <= mod_nxt;
    u0_r      <= u0_nxt;
    u1_r      <= u1_nxt;
    d_r       <= d_nxt;
    v_r       <= v_nxt;
    k_r       <= k_nxt;
    neg0_r    <= neg0_nxt;
    neg1_r    <= neg1_nxt;
    out_inv_r <= out_inv_nxt;
    out_stat_r <= out_stat_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_inv_r;
  assign out_tuser  = out_stat_r;

endmodule

FILE: rtl/modular_inverse.sv
// Modular inverse by the extended Euclidean algorithm. Each input word carries a value and a
// modulus; each output word carries the inverse in 0..modulus-1 and, in out_tuser, a status bit
// (0 inverse found, 1 none: modulus at most 1 or gcd not 1, inverse then 0). Operands are the low
// WIDTH bits of the 32-bit fields. One item is worked at a time; a new word is taken once the
// previous result sits in the output register. A shift-subtract divider runs every quotient step:
// the value is first reduced modulo the modulus, then the Euclid steps follow, one division per
// quotient. A modulus of 0 or 1 skips the divider.
module modular_inverse #(
  parameter int WIDTH = modinv_pkg::WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [modinv_pkg::IN_TDATA_W-1:0]  in_tdata,   // value[31:0], modulus[63:32]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [modinv_pkg::OUT_TDATA_W-1:0] out_tdata,  // inverse[31:0]
  output logic                               out_tuser   // status[0]
);

  modinv_pkg::cmd_t  cmd;
  modinv_pkg::stat_t stat;

  modinv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  modinv_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: rtl/modinv_chk.sv
`include "modular_inverse_macros.svh"

module modinv_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic [modinv_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [modinv_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                               out_tuser
);

  `MI_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)
  `MI_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  `MI_ASSERT_SAME(a_fail_zero, out_tvalid && out_tuser, out_tdata == '0)
  `MI_ASSERT_SAME(a_ok_nonzero, out_tvalid && !out_tuser, out_tdata != '0)

endmodule

bind modular_inverse modinv_chk u_chk (.*);
